/* hdl/assert_macros.svh */
// Assertion macros shared by the parser modules; they sample on clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/tlvp_pkg.sv */
// Types and constants shared by the TLV element header parser modules.
package tlvp_pkg;

	localparam int TAG_W    = 28;
	localparam int LEN_W    = 16;
	localparam int OFF_W    = 16;
	localparam int COUNT_W  = 16;
	localparam int KIND_W   = 2;
	localparam int OUT_W    = 80;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	localparam logic [7:0] TAG_LOW_MASK  = 8'h1F;
	localparam logic [7:0] GROUP_MASK    = 8'h7F;
	localparam logic [7:0] MORE_BIT      = 8'h80;
	localparam logic [7:0] COMPOSITE_BIT = 8'h20;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEADER  = 2'd0,
		KIND_END_OK  = 2'd1,
		KIND_END_BAD = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_TAG_FIRST = 5'b00001,
		PH_TAG_MORE  = 5'b00010,
		PH_LEN_FIRST = 5'b00100,
		PH_LEN_MORE  = 5'b01000,
		PH_VALUE     = 5'b10000
	} phase_t;

	// One queue entry: the results caused by one byte.
	typedef struct packed {
		logic               has_hdr;
		logic [TAG_W-1:0]   tag;
		logic               comp;
		logic [LEN_W-1:0]   len;
		logic [OFF_W-1:0]   off;
		logic               has_sum;
		logic               sum_ok;
		logic [COUNT_W-1:0] count;
	} rec_t;

endpackage

/* hdl/tlv_element_header_parser.sv */
// Usage: TLV element header parser, one buffer byte per s_axis beat, results on m_axis.
// s_axis carries one byte of the buffer in tdata[7:0]; tlast marks the final byte.
// For each element whose length field completes, one header beat leaves on m_axis
// (tuser = element header) with tag number, composite flag, value length and the
// buffer offset of the first value byte. The final byte yields a summary beat with
// tlast set: tuser says ok or malformed, and item_count holds the element count, or zero if malformed.
// When one byte closes both a header and the buffer, the header beat comes first.
// A byte is taken every cycle while the record queue is not full; each result passes through
// the record queue and the output register, and a summary that follows its header is the next beat.
// The front end and the output register are parted by a four-entry record queue, so
// s_axis_tready stays high while the receiver stalls until four records are waiting.
// Reset clears the parser state, empties the queue and drops m_axis_tvalid; after
// every summary the parser starts over with a fresh buffer at position zero.
module tlv_element_header_parser #(
	parameter int BUFFER_BYTES     = 65536,
	parameter int MAX_TAG_BYTES    = 4,
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // data_byte[7:0]
	input  logic                        s_axis_tlast,  // last_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// tag number[27:0], composite[28], value_length[44:29], value_offset[60:45],
	// item_count[76:61], zero pad[79:77]
	output logic [tlvp_pkg::OUT_W-1:0]  m_axis_tdata,
	output logic [tlvp_pkg::KIND_W-1:0] m_axis_tuser,  // kind[1:0]
	output logic                        m_axis_tlast   // last_result
);
	import tlvp_pkg::*;

	logic full;
	logic empty;
	logic accept;
	logic push;
	logic pop;
	rec_t push_rec;
	rec_t pop_rec;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	tlvp_front #(
		.BUFFER_BYTES     (BUFFER_BYTES),
		.MAX_TAG_BYTES    (MAX_TAG_BYTES),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.push      (push),
		.rec       (push_rec)
	);

	tlvp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (empty)
	);

	tlvp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (pop_rec),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

/* hdl/tlvp_front.sv */
// Front end: walks the TLV byte stream and builds one result record per byte that causes results.
module tlvp_front #(
	parameter int BUFFER_BYTES     = 65536,
	parameter int MAX_TAG_BYTES    = 4,
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output logic          push,
	output tlvp_pkg::rec_t rec
);
	import tlvp_pkg::*;

	localparam int POS_W = $clog2(BUFFER_BYTES + 1);

	phase_t             phase_q, phase_n;
	logic [TAG_W-1:0]   tag_q, tag_n;
	logic [2:0]         tag_seen_q, tag_seen_n;
	logic               comp_q, comp_n;
	logic [2:0]         len_left_q, len_left_n;
	logic [LEN_W-1:0]   len_acc_q, len_acc_n;
	logic               len_ovf_q, len_ovf_n;
	logic [LEN_W-1:0]   val_left_q, val_left_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [COUNT_W-1:0] cnt_q, cnt_n;
	logic               err_q, err_n;
	logic               hdr;
	logic [LEN_W-1:0]   hdr_len;
	logic               ok;
	logic               pos_full;
	logic [31:0]        pos_ext;

	assign pos_full = (pos_q == POS_W'(BUFFER_BYTES));
	assign pos_ext  = 32'(pos_q);

	always_comb begin
		logic [6:0] cnt_bytes;
		phase_n    = phase_q;
		tag_n      = tag_q;
		tag_seen_n = tag_seen_q;
		comp_n     = comp_q;
		len_left_n = len_left_q;
		len_acc_n  = len_acc_q;
		len_ovf_n  = len_ovf_q;
		val_left_n = val_left_q;
		err_n      = err_q | pos_full;
		hdr        = 1'b0;
		hdr_len    = '0;
		cnt_bytes  = data_byte[6:0];
		if (!err_n) begin
			unique case (phase_q)
				PH_TAG_FIRST: begin
					comp_n = |(data_byte & COMPOSITE_BIT);
					if ((data_byte & TAG_LOW_MASK) == TAG_LOW_MASK) begin
						tag_n      = '0;
						tag_seen_n = 3'd0;
						phase_n    = PH_TAG_MORE;
					end else begin
						tag_n      = TAG_W'(data_byte & GROUP_MASK);
						tag_seen_n = 3'd1;
						if (!(|(data_byte & MORE_BIT)) || tag_seen_n >= 3'(MAX_TAG_BYTES))
							phase_n = PH_LEN_FIRST;
						else
							phase_n = PH_TAG_MORE;
					end
				end
				PH_TAG_MORE: begin
					tag_n      = {tag_q[TAG_W-8:0], data_byte[6:0]};
					tag_seen_n = tag_seen_q + 3'd1;
					if (!(|(data_byte & MORE_BIT)) || tag_seen_n >= 3'(MAX_TAG_BYTES))
						phase_n = PH_LEN_FIRST;
					else
						phase_n = PH_TAG_MORE;
				end
				PH_LEN_FIRST: begin
					if (!data_byte[7]) begin
						hdr     = 1'b1;
						hdr_len = LEN_W'(data_byte);
					end else if (cnt_bytes == 7'd0) begin
						hdr     = 1'b1;
						hdr_len = '0;
					end else if (cnt_bytes > 7'(MAX_LENGTH_BYTES)) begin
						err_n = 1'b1;
					end else begin
						len_left_n = cnt_bytes[2:0];
						len_acc_n  = '0;
						len_ovf_n  = 1'b0;
						phase_n    = PH_LEN_MORE;
					end
				end
				PH_LEN_MORE: begin
					// Only the low 16 bits are kept; anything shifted out marks overflow.
					len_acc_n  = {len_acc_q[7:0], data_byte};
					len_ovf_n  = len_ovf_q | (|len_acc_q[15:8]);
					len_left_n = len_left_q - 3'd1;
					if (len_left_n == 3'd0) begin
						if (len_ovf_n) begin
							err_n = 1'b1;
						end else begin
							hdr     = 1'b1;
							hdr_len = len_acc_n;
						end
					end
				end
				PH_VALUE: begin
					val_left_n = val_left_q - LEN_W'(1);
					if (val_left_n == '0)
						phase_n = PH_TAG_FIRST;
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end
		if (hdr) begin
			val_left_n = hdr_len;
			phase_n    = (hdr_len == '0) ? PH_TAG_FIRST : PH_VALUE;
		end
		cnt_n = (hdr && cnt_q != {COUNT_W{1'b1}}) ? cnt_q + COUNT_W'(1) : cnt_q;
		pos_n = pos_full ? pos_q : pos_q + POS_W'(1);
		ok    = !err_n && phase_n == PH_TAG_FIRST;
	end

	assign push        = accept && (hdr || last_byte);
	assign rec.has_hdr = hdr;
	assign rec.tag     = tag_n;
	assign rec.comp    = comp_n;
	assign rec.len     = hdr_len;
	assign rec.off     = OFF_W'(pos_ext + 32'd1);
	assign rec.has_sum = last_byte;
	assign rec.sum_ok  = ok;
	assign rec.count   = ok ? cnt_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			tag_q      <= '0;
			tag_seen_q <= '0;
			comp_q     <= 1'b0;
			len_left_q <= '0;
			len_acc_q  <= '0;
			len_ovf_q  <= 1'b0;
			val_left_q <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			err_q      <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				// A summary closes the buffer; the next beat starts a new one.
				phase_q    <= PH_TAG_FIRST;
				tag_q      <= '0;
				tag_seen_q <= '0;
				comp_q     <= 1'b0;
				len_left_q <= '0;
				len_acc_q  <= '0;
				len_ovf_q  <= 1'b0;
				val_left_q <= '0;
				pos_q      <= '0;
				cnt_q      <= '0;
				err_q      <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				tag_q      <= tag_n;
				tag_seen_q <= tag_seen_n;
				comp_q     <= comp_n;
				len_left_q <= len_left_n;
				len_acc_q  <= len_acc_n;
				len_ovf_q  <= len_ovf_n;
				val_left_q <= val_left_n;
				pos_q      <= pos_n;
				cnt_q      <= cnt_n;
				err_q      <= err_n;
			end
		end
	end

`include "assert_macros.svh"

	`ASSERT_NEXT(a_clear_after_last, accept && last_byte, pos_q == '0 && cnt_q == '0 && !err_q, "state not cleared after summary")

endmodule

/* hdl/tlvp_queue.sv */
// Short queue of result records between the parser front end and the output stage.
module tlvp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlvp_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output tlvp_pkg::rec_t pop_rec,
	output logic           empty
);
	import tlvp_pkg::*;

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_no_push_full, full, !push, "record pushed into a full queue")
	`ASSERT_IMPLIES(a_no_pop_empty, empty, !pop, "record popped from an empty queue")

endmodule

/* hdl/tlvp_back.sv */
// Output stage: turns queued records into header and summary beats on the result stream.
module tlvp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tlvp_pkg::rec_t             rec,
	input  logic                       empty,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tlvp_pkg::OUT_W-1:0] m_tdata,
	output logic [tlvp_pkg::KIND_W-1:0] m_tuser,
	output logic                       m_tlast
);
	import tlvp_pkg::*;

	logic                valid_q;
	logic [OUT_W-1:0]    data_q;
	kind_t               kind_q;
	logic                last_q;
	logic                pend_q;
	logic                pend_ok_q;
	logic [COUNT_W-1:0]  pend_cnt_q;
	logic                load;

	function automatic logic [OUT_W-1:0] pack_beat(logic [TAG_W-1:0] tag, logic comp,
			logic [LEN_W-1:0] len, logic [OFF_W-1:0] off, logic [COUNT_W-1:0] count);
		return {3'b000, count, off, len, comp, tag};
	endfunction

	assign load = !valid_q || m_tready;
	assign pop  = load && !pend_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pend_q     <= 1'b0;
			pend_ok_q  <= 1'b0;
			pend_cnt_q <= '0;
			data_q     <= '0;
			kind_q     <= KIND_HEADER;
			last_q     <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
				data_q  <= pack_beat('0, 1'b0, '0, '0, pend_cnt_q);
				kind_q  <= pend_ok_q ? KIND_END_OK : KIND_END_BAD;
				last_q  <= 1'b1;
			end else if (!empty) begin
				valid_q <= 1'b1;
				if (rec.has_hdr) begin
					// The summary of the same byte follows the header one beat later.
					pend_q     <= rec.has_sum;
					pend_ok_q  <= rec.sum_ok;
					pend_cnt_q <= rec.count;
					data_q     <= pack_beat(rec.tag, rec.comp, rec.len, rec.off, '0);
					kind_q     <= KIND_HEADER;
					last_q     <= 1'b0;
				end else begin
					data_q <= pack_beat('0, 1'b0, '0, '0, rec.count);
					kind_q <= rec.sum_ok ? KIND_END_OK : KIND_END_BAD;
					last_q <= 1'b1;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_pend_shown, pend_q, valid_q && !last_q, "pending summary without its header beat")
	`ASSERT_IMPLIES(a_last_kind, valid_q, last_q == (kind_q != KIND_HEADER), "beat kind disagrees with tlast")

endmodule
